/* rtl/smsa_pkg.sv */
// Shared types, codes and constants for the size-matched slot allocator.
// Used by the controller, the datapath, the top level and the checker.
`default_nettype none

package smsa_pkg;

	localparam int SLOT_COUNT_DEF = 16;
	localparam int ADDR_W         = 48;
	localparam int SIZE_W         = 48;
	localparam int IDX_OUT_W      = 4;

	localparam logic CMD_ALLOC   = 1'b0;
	localparam logic CMD_RELEASE = 1'b1;

	// Outcome of one scan.
	localparam logic [1:0] KIND_MISS  = 2'd0;
	localparam logic [1:0] KIND_REUSE = 2'd1;
	localparam logic [1:0] KIND_NEW   = 2'd2;
	localparam logic [1:0] KIND_REL   = 2'd3;

	// One slot of the table. Slots past the fill count have never been used.
	typedef struct packed {
		logic              in_use;
		logic [SIZE_W-1:0] size;
		logic [ADDR_W-1:0] addr;
	} slot_entry_t;

	typedef struct packed {
		logic start;
		logic scan;
		logic commit;
	} smsa_cmd_t;

	typedef struct packed {
		logic finish;
	} smsa_sts_t;

endpackage

`default_nettype wire

/* rtl/smsa_ctrl.sv */
// Sequencer for the slot allocator: takes a request, runs the slot scan,
// then commits the update and the result. Depends on smsa_pkg.
`default_nettype none

module smsa_ctrl
	import smsa_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_stall,
	output logic           out_valid,
	input  wire logic      out_stall,
	input  wire smsa_sts_t sts,
	output smsa_cmd_t      cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_UPD  = 2'd2;

	logic [1:0] state_q;
	logic       out_valid_q;
	logic       out_room;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_room  = !out_valid_q || !out_stall;

	always_comb begin
		cmd.start  = (state_q == ST_IDLE) && in_valid;
		cmd.scan   = (state_q == ST_SCAN);
		cmd.commit = (state_q == ST_UPD) && out_room;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (sts.finish) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					if (out_room) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/smsa_dp.sv */
// Datapath of the slot allocator: request registers, slot memory with a
// registered read, scan compare, fill count and result registers. Uses smsa_pkg.
`default_nettype none

module smsa_dp
	import smsa_pkg::*;
#(
	parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire smsa_cmd_t            cmd,
	output smsa_sts_t                 sts,
	input  wire logic                 req_cmd,
	input  wire logic [SIZE_W-1:0]    req_size,
	input  wire logic [ADDR_W-1:0]    fresh_addr,
	input  wire logic [ADDR_W-1:0]    release_addr,
	output logic      [ADDR_W-1:0]    out_addr,
	output logic                      hit,
	output logic                      took_new,
	output logic      [IDX_OUT_W-1:0] slot_index
);

	localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int CW = $clog2(SLOT_COUNT + 1);
	localparam logic [CW-1:0] SLOT_COUNT_C = CW'(SLOT_COUNT);

	slot_entry_t mem [SLOT_COUNT];

	logic              cmd_q;
	logic [SIZE_W-1:0] size_q;
	logic [ADDR_W-1:0] fresh_q;
	logic [ADDR_W-1:0] rel_q;
	logic [CW-1:0]     fill_q;
	logic [CW-1:0]     scan_q;
	logic              chk_vld_s1;
	logic [IW-1:0]     chk_idx_s1;
	slot_entry_t       rd_s1;
	logic [1:0]        kind_q;
	logic [IW-1:0]     sel_q;

	logic              zero_alloc;
	logic              match;
	logic              scan_done;
	logic              finish;
	logic              rd_en;
	logic [1:0]        kind_d;
	logic              mem_we;
	slot_entry_t       mem_wd;
	logic [IW+IDX_OUT_W-1:0] sel_ext;

	assign zero_alloc = (cmd_q == CMD_ALLOC) && (size_q == '0);

	always_comb begin
		if (cmd_q == CMD_RELEASE) begin
			match = chk_vld_s1 && (rd_s1.addr == rel_q);
		end else begin
			match = chk_vld_s1 && !rd_s1.in_use && (rd_s1.size == size_q) && !zero_alloc;
		end
	end

	assign scan_done  = !chk_vld_s1 && (scan_q >= fill_q);
	assign finish     = match || scan_done || zero_alloc;
	assign sts.finish = finish;
	assign rd_en      = cmd.scan && !finish && (scan_q < fill_q);

	always_comb begin
		if (match) begin
			kind_d = (cmd_q == CMD_RELEASE) ? KIND_REL : KIND_REUSE;
		end else if (!zero_alloc && (cmd_q == CMD_ALLOC) && (fill_q < SLOT_COUNT_C)) begin
			kind_d = KIND_NEW;
		end else begin
			kind_d = KIND_MISS;
		end
	end

	always_comb begin
		mem_we = cmd.commit && (kind_q != KIND_MISS);
		if (kind_q == KIND_NEW) begin
			mem_wd.in_use = 1'b1;
			mem_wd.size   = size_q;
			mem_wd.addr   = fresh_q;
		end else begin
			// A release clears the in-use mark; a reuse sets it. A slot that is
			// already free simply stays free.
			mem_wd.in_use = (kind_q == KIND_REUSE);
			mem_wd.size   = rd_s1.size;
			mem_wd.addr   = rd_s1.addr;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[sel_q] <= mem_wd;
		end
		if (rd_en) begin
			rd_s1 <= mem[scan_q[IW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q     <= '0;
			chk_vld_s1 <= 1'b0;
		end else begin
			chk_vld_s1 <= rd_en;
			if (cmd.commit && (kind_q == KIND_NEW)) begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			cmd_q   <= req_cmd;
			size_q  <= req_size;
			fresh_q <= fresh_addr;
			rel_q   <= release_addr;
			scan_q  <= '0;
		end else if (rd_en) begin
			scan_q <= scan_q + 1'b1;
		end
		if (rd_en) begin
			chk_idx_s1 <= scan_q[IW-1:0];
		end
		if (cmd.scan && finish) begin
			kind_q <= kind_d;
			sel_q  <= match ? chk_idx_s1 : fill_q[IW-1:0];
		end
	end

	assign sel_ext = {{IDX_OUT_W{1'b0}}, sel_q};

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			case (kind_q)
				KIND_REUSE: out_addr <= rd_s1.addr;
				KIND_NEW:   out_addr <= fresh_q;
				default:    out_addr <= '0;
			endcase
			hit        <= (kind_q != KIND_MISS);
			took_new   <= (kind_q == KIND_NEW);
			slot_index <= (kind_q != KIND_MISS) ? sel_ext[IDX_OUT_W-1:0] : '0;
		end
	end

endmodule

`default_nettype wire

/* rtl/size_matched_slot_allocator.sv */
// Top level of the size-matched slot allocator: joins the controller and
// the datapath. Depends on smsa_pkg, smsa_ctrl and smsa_dp.
`default_nettype none

// The allocator keeps SLOT_COUNT slots, each with a size, an address and an
// in-use mark. An allocate transfer reuses the first free slot of exactly the
// requested size, or else claims the next never-used slot with fresh_addr; a
// release transfer frees the first slot holding release_addr, in use or free.
// Requests are handled one at a time: in_stall is high from the accepting edge
// until the result is written to the output register. A request is taken, then
// each used slot is read in turn through the registered read of the slot
// memory, the end of the scan is seen, and an update state writes the result;
// the single read port of the slot memory makes the scan read one slot at a
// time. A zero-size allocate or a request on an empty table reads no slot.
// The next request is taken while the previous result still waits on out_stall.
// Used slots always form a prefix of the table, so a fill count, cleared at
// reset, stands for the cleared state and no clearing pass is needed.
module size_matched_slot_allocator
	import smsa_pkg::*;
#(
	parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic                 cmd,
	input  wire logic [SIZE_W-1:0]    req_size,
	input  wire logic [ADDR_W-1:0]    fresh_addr,
	input  wire logic [ADDR_W-1:0]    release_addr,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic      [ADDR_W-1:0]    out_addr,
	output logic                      hit,
	output logic                      took_new,
	output logic      [IDX_OUT_W-1:0] slot_index
);

	smsa_cmd_t ctl_cmd;
	smsa_sts_t dp_sts;

	smsa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (dp_sts),
		.cmd       (ctl_cmd)
	);

	smsa_dp #(
		.SLOT_COUNT (SLOT_COUNT)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (ctl_cmd),
		.sts          (dp_sts),
		.req_cmd      (cmd),
		.req_size     (req_size),
		.fresh_addr   (fresh_addr),
		.release_addr (release_addr),
		.out_addr     (out_addr),
		.hit          (hit),
		.took_new     (took_new),
		.slot_index   (slot_index)
	);

endmodule

`default_nettype wire

/* rtl/smsa_checker.sv */
// Port-level checks for the slot allocator, bound to the top level.
// Depends on smsa_pkg and size_matched_slot_allocator.
`default_nettype none

module smsa_checker
	import smsa_pkg::*;
(
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 in_valid,
	input wire logic                 in_stall,
	input wire logic                 out_valid,
	input wire logic                 out_stall,
	input wire logic [ADDR_W-1:0]    out_addr,
	input wire logic                 hit,
	input wire logic                 took_new,
	input wire logic [IDX_OUT_W-1:0] slot_index
);

	// A held result must not change while the receiver stalls.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_addr) && $stable(hit)
			&& $stable(took_new) && $stable(slot_index))
		else $error("result changed while stalled");

	// A miss reports a null address and no slot.
	a_miss_null: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> (out_addr == '0) && !took_new && (slot_index == '0))
		else $error("miss result carries data");

	// Claiming a new slot is always a hit.
	a_new_hit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && took_new |-> hit)
		else $error("new slot reported without hit");

	// Requests are served one at a time: after a transfer in, the input stalls.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second request taken while busy");

endmodule

bind size_matched_slot_allocator smsa_checker u_smsa_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.out_addr   (out_addr),
	.hit        (hit),
	.took_new   (took_new),
	.slot_index (slot_index)
);

`default_nettype wire
